// ===== src/solenoid_boost_hold_controller_defines.svh =====
// ----------------------------------------------------------------------------
// Solenoid boost/hold controller assertion macros
// Shared property macros for the checker. They expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SOLENOID_BOOST_HOLD_CONTROLLER_DEFINES_SVH
`define SOLENOID_BOOST_HOLD_CONTROLLER_DEFINES_SVH

// Overlapping implication, sampled on the rising clock edge, off during reset.
`define SBHC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the clock cycle after the antecedent.
`define SBHC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sbhc_pkg.sv =====
// ----------------------------------------------------------------------------
// Solenoid boost/hold controller package
// Sizes, opcodes, status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package sbhc_pkg;

	localparam int GROUPS     = 6;
	// Only the first six groups fit the result masks.
	localparam int OUT_GROUPS = (GROUPS < 6) ? GROUPS : 6;

	localparam int VMASK_W    = 18;
	localparam int BMASK_W    = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [1:0] OP_VALVE   = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_ALL_OFF = 2'd2;

	localparam logic [1:0] KIND_TEST  = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_INDEX = 3'd1;
	localparam logic [2:0] ST_ZERO_PULL = 3'd2;
	localparam logic [2:0] ST_INTERVAL  = 3'd3;
	localparam logic [2:0] ST_DISABLED  = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUTS_EN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd2;

	localparam logic [15:0] MIN_INTERVAL_RST = 16'd1000;

	function automatic logic [VMASK_W-1:0] valve_exist_mask();
		logic [VMASK_W-1:0] m;
		m = '0;
		for (int i = 0; i < OUT_GROUPS; i++) begin
			m[3*i +: 3] = 3'b111;
		end
		return m;
	endfunction

	function automatic logic [BMASK_W-1:0] boost_exist_mask();
		logic [BMASK_W-1:0] m;
		m = '0;
		for (int i = 0; i < OUT_GROUPS; i++) begin
			m[i] = 1'b1;
		end
		return m;
	endfunction

	localparam logic [VMASK_W-1:0] VALVE_EXIST = valve_exist_mask();
	localparam logic [BMASK_W-1:0] BOOST_EXIST = boost_exist_mask();

endpackage

// ===== src/sbhc_if.sv =====
// ----------------------------------------------------------------------------
// Solenoid boost/hold controller channels
// Command, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface sbhc_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [1:0]  valve_kind;
	logic [2:0]  group;
	logic        turn_on;
	logic [15:0] pull_in_ms;
	logic [31:0] now_ms;

	modport source (output valid, opcode, valve_kind, group, turn_on, pull_in_ms, now_ms,
		input ready);
	modport sink (input valid, opcode, valve_kind, group, turn_on, pull_in_ms, now_ms,
		output ready);
endinterface

interface sbhc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  status;
	logic [sbhc_pkg::VMASK_W-1:0] valve_open_mask;
	logic [sbhc_pkg::BMASK_W-1:0] boost_on_mask;
	logic [sbhc_pkg::VMASK_W-1:0] valve_pins;
	logic [sbhc_pkg::BMASK_W-1:0] boost_pins;

	modport source (output valid, status, valve_open_mask, boost_on_mask, valve_pins,
		boost_pins, input ready);
	modport sink (input valid, status, valve_open_mask, boost_on_mask, valve_pins,
		boost_pins, output ready);
endinterface

interface sbhc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [sbhc_pkg::CFG_IDX_W-1:0]  index;
	logic [sbhc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/solenoid_boost_hold_controller.sv =====
// ----------------------------------------------------------------------------
// Solenoid boost/hold controller
// Peak-and-hold valve driver for several groups with a shared boost line each.
// ----------------------------------------------------------------------------
//  Channel | Dir | Word contents
//  --------+-----+----------------------------------------------------------
//  cmd     | in  | opcode, valve_kind, group, turn_on, pull_in_ms, now_ms
//  rsp     | out | status, valve_open_mask, boost_on_mask, valve_pins, boost_pins
//  cfg     | in  | index, data (register write, always ready)
//
// Each command word is held in the input register and is then
// evaluated in one pass against the group state; its response is then
// written to the output register. One word per cycle is sustained while rsp is ready.
// Reset clears all valves, boosts, deadlines and intervals and loads the
// register defaults. A stalled response holds the input register, which then
// stalls cmd; words keep flowing while the response register is being drained.
module solenoid_boost_hold_controller (
	input  logic      clk,
	input  logic      arst_n,
	sbhc_cfg_if.sink  cfg,
	sbhc_cmd_if.sink  cmd,
	sbhc_rsp_if.source rsp
);
	import sbhc_pkg::*;

	function automatic logic reached(input logic [31:0] now, input logic [31:0] at);
		logic [31:0] diff;
		diff = now - at;
		return !diff[31];
	endfunction

	// Configuration registers.
	logic        active_high_q;
	logic        outputs_enabled_q;
	logic [15:0] min_interval_q;

	// Input register.
	logic        valid_s1;
	logic [1:0]  opcode_s1;
	logic [1:0]  kind_s1;
	logic [2:0]  group_s1;
	logic        turn_on_s1;
	logic [15:0] pull_s1;
	logic [31:0] now_s1;

	// Group state.
	logic [2:0]        valve_open_q [GROUPS];
	logic [GROUPS-1:0] boost_on_q;
	logic [GROUPS-1:0] pending_q;
	logic [31:0]       deadline_q   [GROUPS];
	logic [31:0]       allowed_q    [GROUPS];

	logic [2:0]        valve_open_d [GROUPS];
	logic [GROUPS-1:0] boost_on_d;
	logic [GROUPS-1:0] pending_d;
	logic [31:0]       deadline_d   [GROUPS];
	logic [31:0]       allowed_d    [GROUPS];

	// Response register.
	logic               rsp_valid_q;
	logic [2:0]         status_q;
	logic [VMASK_W-1:0] vmask_q;
	logic [BMASK_W-1:0] bmask_q;
	logic [VMASK_W-1:0] vpins_q;
	logic [BMASK_W-1:0] bpins_q;

	logic               step;
	logic               group_ok;
	logic               kind_ok;
	logic [2:0]         kind_bit;
	logic [31:0]        open_deadline;
	logic [31:0]        open_allowed;
	logic [2:0]         status_d;
	logic [2:0]         closed_vo;
	logic [VMASK_W-1:0] vmask_d;
	logic [BMASK_W-1:0] bmask_d;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_high_q     <= 1'b1;
			outputs_enabled_q <= 1'b1;
			min_interval_q    <= MIN_INTERVAL_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ACTIVE_HIGH:  active_high_q     <= cfg.data[0];
				CFG_OUTPUTS_EN:   outputs_enabled_q <= cfg.data[0];
				CFG_MIN_INTERVAL: min_interval_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	assign step      = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			opcode_s1  <= cmd.opcode;
			kind_s1    <= cmd.valve_kind;
			group_s1   <= cmd.group;
			turn_on_s1 <= cmd.turn_on;
			pull_s1    <= cmd.pull_in_ms;
			now_s1     <= cmd.now_ms;
		end
	end

	assign group_ok      = {1'b0, group_s1} < 4'(GROUPS);
	assign kind_ok       = kind_s1 <= KIND_TEST;
	assign kind_bit      = 3'b001 << kind_s1;
	assign open_deadline = now_s1 + {16'd0, pull_s1};
	assign open_allowed  = now_s1 + {16'd0, min_interval_q};

	always_comb begin
		valve_open_d = valve_open_q;
		boost_on_d   = boost_on_q;
		pending_d    = pending_q;
		deadline_d   = deadline_q;
		allowed_d    = allowed_q;
		status_d     = ST_OK;
		closed_vo    = 3'd0;
		case (opcode_s1)
			OP_VALVE: begin
				if (!kind_ok || !group_ok) begin
					status_d = ST_BAD_INDEX;
				end else if (turn_on_s1 && !outputs_enabled_q) begin
					status_d = ST_DISABLED;
				end else if (turn_on_s1 && (pull_s1 == 16'd0)) begin
					status_d = ST_ZERO_PULL;
				end else begin
					for (int i = 0; i < GROUPS; i++) begin
						if (group_s1 == 3'(i)) begin
							if (turn_on_s1) begin
								if ((valve_open_q[i] & kind_bit) != 3'd0) begin
									status_d = ST_OK;
								end else if (pending_q[i] && !reached(now_s1, allowed_q[i])) begin
									status_d = ST_INTERVAL;
								end else begin
									boost_on_d[i]   = 1'b1;
									pending_d[i]    = 1'b1;
									allowed_d[i]    = open_allowed;
									valve_open_d[i] = valve_open_q[i] | kind_bit;
									deadline_d[i]   = open_deadline;
								end
							end else begin
								closed_vo       = valve_open_q[i] & ~kind_bit;
								valve_open_d[i] = closed_vo;
								if (closed_vo == 3'd0) begin
									boost_on_d[i] = 1'b0;
									deadline_d[i] = 32'd0;
								end
							end
						end
					end
				end
			end
			OP_TICK: begin
				for (int i = 0; i < GROUPS; i++) begin
					if (pending_q[i] && reached(now_s1, allowed_q[i])) begin
						pending_d[i] = 1'b0;
					end
					if (boost_on_q[i] && reached(now_s1, deadline_q[i])) begin
						boost_on_d[i] = 1'b0;
						deadline_d[i] = 32'd0;
					end
				end
			end
			OP_ALL_OFF: begin
				for (int i = 0; i < GROUPS; i++) begin
					valve_open_d[i] = 3'd0;
					boost_on_d[i]   = 1'b0;
					deadline_d[i]   = 32'd0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		vmask_d = '0;
		bmask_d = '0;
		for (int i = 0; i < OUT_GROUPS; i++) begin
			vmask_d[3*i +: 3] = valve_open_d[i];
			bmask_d[i]        = boost_on_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boost_on_q <= '0;
			pending_q  <= '0;
			for (int i = 0; i < GROUPS; i++) begin
				valve_open_q[i] <= 3'd0;
				deadline_q[i]   <= 32'd0;
				allowed_q[i]    <= 32'd0;
			end
		end else if (step) begin
			boost_on_q   <= boost_on_d;
			pending_q    <= pending_d;
			valve_open_q <= valve_open_d;
			deadline_q   <= deadline_d;
			allowed_q    <= allowed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (step) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			status_q <= status_d;
			vmask_q  <= vmask_d;
			bmask_q  <= bmask_d;
			vpins_q  <= active_high_q ? vmask_d : (~vmask_d & VALVE_EXIST);
			bpins_q  <= active_high_q ? bmask_d : (~bmask_d & BOOST_EXIST);
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = status_q;
	assign rsp.valve_open_mask = vmask_q;
	assign rsp.boost_on_mask   = bmask_q;
	assign rsp.valve_pins      = vpins_q;
	assign rsp.boost_pins      = bpins_q;

endmodule

// ===== src/sbhc_checker.sv =====
// ----------------------------------------------------------------------------
// Solenoid boost/hold controller checker
// Port-level properties of the response stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "solenoid_boost_hold_controller_defines.svh"

module sbhc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [2:0]                   rsp_status,
	input logic [sbhc_pkg::VMASK_W-1:0] rsp_vmask,
	input logic [sbhc_pkg::BMASK_W-1:0] rsp_bmask,
	input logic [sbhc_pkg::VMASK_W-1:0] rsp_vpins,
	input logic [sbhc_pkg::BMASK_W-1:0] rsp_bpins
);
	import sbhc_pkg::*;

	logic               rsp_fire;
	logic               pol_ok;
	logic               unchanged;
	logic [BMASK_W-1:0] group_any;
	logic [VMASK_W-1:0] last_vmask_q;
	logic [BMASK_W-1:0] last_bmask_q;

	assign rsp_fire = rsp_valid && rsp_ready;

	// The pins either follow the masks or are their complement over present groups.
	assign pol_ok = ((rsp_vpins == rsp_vmask) && (rsp_bpins == rsp_bmask)) ||
		((rsp_vpins == (~rsp_vmask & VALVE_EXIST)) && (rsp_bpins == (~rsp_bmask & BOOST_EXIST)));

	assign unchanged = (rsp_vmask == last_vmask_q) && (rsp_bmask == last_bmask_q);

	always_comb begin
		group_any = '0;
		for (int i = 0; i < OUT_GROUPS; i++) begin
			group_any[i] = |rsp_vmask[3*i +: 3];
		end
	end

	// A refused command leaves the state as the previous word showed it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_vmask_q <= '0;
			last_bmask_q <= '0;
		end else if (rsp_fire) begin
			last_vmask_q <= rsp_vmask;
			last_bmask_q <= rsp_bmask;
		end
	end

	`SBHC_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_vmask) && $stable(rsp_bmask), "response word changed while stalled")
	`SBHC_ASSERT_IMP(a_pin_polarity, rsp_valid, pol_ok, "pin levels disagree with masks")
	`SBHC_ASSERT_IMP(a_boost_needs_valve, rsp_valid, (rsp_bmask & ~group_any) == '0, "boost active on a group with no open valve")
	`SBHC_ASSERT_IMP(a_refusal_no_change, rsp_fire && (rsp_status != ST_OK), unchanged, "refused command changed valve or boost state")

endmodule

bind solenoid_boost_hold_controller sbhc_checker u_sbhc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_vmask  (rsp.valve_open_mask),
	.rsp_bmask  (rsp.boost_on_mask),
	.rsp_vpins  (rsp.valve_pins),
	.rsp_bpins  (rsp.boost_pins)
);
